// File: hw/rtl/vf_startup_ramp_three_phase_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the V/f start-up ramp block
// Every macro is sampled on clk_i and is switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VF_STARTUP_RAMP_THREE_PHASE_DEFINES_SVH
`define VF_STARTUP_RAMP_THREE_PHASE_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent
`define VSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent
`define VSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vsr_pkg.sv
// ----------------------------------------------------------------------------
// vsr_pkg
// Shared types, constants and the sine table builder for the V/f ramp block.
// ----------------------------------------------------------------------------
package vsr_pkg;

  // Sine table geometry
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_LG          = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;
  localparam int MAG_W            = 17;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Phase offsets for the B and C legs
  localparam logic [31:0] OFFSET_B = 32'h5555_5555;
  localparam logic [31:0] OFFSET_C = 32'hAAAA_AAAB;

  // Full-scale amplitude, Q1.16
  localparam logic [16:0] FULL_AMP = 17'd65536;

  // Register reset values
  localparam logic [19:0] RST_RAMP_STEP       = 20'd51;
  localparam logic [23:0] RST_TARGET_SPEED    = 24'd1024000;
  localparam logic [23:0] RST_PHASE_GAIN      = 24'd916259;
  localparam logic [15:0] RST_MIN_AMPLITUDE   = 16'd9830;
  localparam logic [23:0] RST_AMPLITUDE_SLOPE = 24'd11884;
  localparam logic [15:0] RST_TIMEOUT_MS      = 16'd500;

  // Register indexes
  typedef enum logic [2:0] {
    REG_RAMP_STEP       = 3'd0,
    REG_TARGET_SPEED    = 3'd1,
    REG_PHASE_GAIN      = 3'd2,
    REG_MIN_AMPLITUDE   = 3'd3,
    REG_AMPLITUDE_SLOPE = 3'd4,
    REG_TIMEOUT_MS      = 3'd5
  } vsr_reg_e;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TIMEOUT,
    OP_RAMP,
    OP_MUL_PH,
    OP_ACC_PH,
    OP_MUL_AMP,
    OP_AMP_SAT,
    OP_PHASE,
    OP_LOOKUP,
    OP_MUL_DUTY,
    OP_DUTY,
    OP_EMIT
  } vsr_op_e;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_WAIT_IN,
    JC_IF_HOLD,
    JC_WAIT_OUT
  } vsr_jump_e;

  typedef logic [1:0] vsr_lane_t;

  // Microcode word
  typedef struct packed {
    vsr_op_e   op;
    vsr_lane_t lane;
    vsr_jump_e jump;
    logic [4:0] target;
  } vsr_uword_t;

  // Sequencer to datapath
  typedef struct packed {
    vsr_op_e   op;
    vsr_lane_t lane;
    logic      idle;
  } vsr_ctrl_t;

  // Datapath and handshake status back to the sequencer
  typedef struct packed {
    logic in_fire;
    logic rising;
    logic out_free;
  } vsr_status_t;

  // Configuration registers
  typedef struct packed {
    logic [19:0] ramp_step;
    logic [23:0] target_speed;
    logic [23:0] phase_gain;
    logic [15:0] min_amplitude;
    logic [23:0] amplitude_slope;
    logic [15:0] timeout_ms;
  } vsr_cfg_t;

  typedef logic [2:0][15:0] vsr_duty_t;

  typedef logic [MAG_W-1:0] vsr_qtab_t [SINE_QTR];

  // sin of quarter-table point j (angle j/SINE_QTR * pi/2), Q2.15 magnitude.
  // Taylor series to x^11 in Q2.30 with truncated products, then round half up.
  function automatic logic [MAG_W-1:0] vsr_sine_mag(input int unsigned j);
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    logic [63:0] s;
    num  = 64'(j) * 64'd4;
    x    = (num * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 5; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        default: term = prod / 64'd110;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    s = (sum + 64'd16384) >> 15;
    return s[MAG_W-1:0];
  endfunction

  // Quarter-wave table, entries 0 .. SINE_QTR-1
  function automatic vsr_qtab_t vsr_build_qtab();
    vsr_qtab_t t;
    for (int unsigned j = 0; j < SINE_QTR; j++) begin
      t[j] = vsr_sine_mag(j);
    end
    return t;
  endfunction

  // Value at the quarter-turn point
  localparam logic [MAG_W-1:0] SINE_PEAK = vsr_sine_mag(SINE_QTR);

endpackage

// File: hw/rtl/vf_startup_ramp_three_phase.sv
// ----------------------------------------------------------------------------
// vf_startup_ramp_three_phase: open-loop V/f start-up ramp, three sine duties
// Requests are taken only while idle; a new request waits until the last result
// has been emitted, so output stalls also hold off the input. The 21-step
// microprogram shares one 24x24 multiplier and skips the ramp step once stopped.
// Reset: async active low; registers to defaults, speed/phase zero, ramp armed.
// ----------------------------------------------------------------------------
`include "vf_startup_ramp_three_phase_defines.svh"

module vf_startup_ramp_three_phase
  import vsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] duty_a_o,
  output logic [15:0] duty_b_o,
  output logic [15:0] duty_c_o,
  output logic [23:0] speed_now_o,
  output logic        ramping_o,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  vsr_cfg_t    cfg_q;
  vsr_ctrl_t   ctrl;
  vsr_status_t status;
  logic        in_fire;
  logic        out_free;
  logic        emit_fire;
  logic        rising;
  logic [23:0] speed;
  vsr_duty_t   duty;

  logic        out_valid_q;
  logic [15:0] duty_a_q, duty_b_q, duty_c_q;
  logic [23:0] speed_q;
  logic        ramping_q;

  // Handshakes
  assign in_stall_o  = !ctrl.idle;
  assign in_fire     = in_valid_i && ctrl.idle;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_fire   = (ctrl.op == OP_EMIT) && out_free;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_step       <= RST_RAMP_STEP;
      cfg_q.target_speed    <= RST_TARGET_SPEED;
      cfg_q.phase_gain      <= RST_PHASE_GAIN;
      cfg_q.min_amplitude   <= RST_MIN_AMPLITUDE;
      cfg_q.amplitude_slope <= RST_AMPLITUDE_SLOPE;
      cfg_q.timeout_ms      <= RST_TIMEOUT_MS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vsr_reg_e'(cfg_index_i))
        REG_RAMP_STEP:       cfg_q.ramp_step       <= cfg_data_i[19:0];
        REG_TARGET_SPEED:    cfg_q.target_speed    <= cfg_data_i;
        REG_PHASE_GAIN:      cfg_q.phase_gain      <= cfg_data_i;
        REG_MIN_AMPLITUDE:   cfg_q.min_amplitude   <= cfg_data_i[15:0];
        REG_AMPLITUDE_SLOPE: cfg_q.amplitude_slope <= cfg_data_i;
        REG_TIMEOUT_MS:      cfg_q.timeout_ms      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign status.in_fire  = in_fire;
  assign status.rising   = rising;
  assign status.out_free = out_free;

  vsr_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  vsr_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .in_fire_i (in_fire),
    .now_ms_i  (now_ms_i),
    .rising_o  (rising),
    .speed_o   (speed),
    .duty_o    (duty)
  );

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      duty_a_q  <= duty[0];
      duty_b_q  <= duty[1];
      duty_c_q  <= duty[2];
      speed_q   <= speed;
      ramping_q <= rising;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_a_o    = duty_a_q;
  assign duty_b_o    = duty_b_q;
  assign duty_c_o    = duty_c_q;
  assign speed_now_o = speed_q;
  assign ramping_o   = ramping_q;

  // Checks
  `VSR_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall_o, "idle after accepted request")
  `VSR_ASSERT_SAME(a_valid_from_emit, $rose(out_valid_o), $past(emit_fire), "result without emit")
  `VSR_ASSERT_NEXT(a_emit_shows, emit_fire, out_valid_o, "emitted result not shown")

endmodule

// File: hw/rtl/vsr_sine_lut.sv
// ----------------------------------------------------------------------------
// vsr_sine_lut
// Quarter-wave sine lookup with quadrant folding; magnitude and sign registered.
// ----------------------------------------------------------------------------
module vsr_sine_lut
  import vsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SINE_LG-1:0] idx_i,
  output logic [MAG_W-1:0]   mag_o,
  output logic               neg_o
);

  localparam vsr_qtab_t           QTAB  = vsr_build_qtab();
  localparam logic [SINE_LG-2:0]  QTR_J = (SINE_LG-1)'(SINE_QTR);

  logic [1:0]         quad;
  logic [SINE_LG-3:0] r;
  logic [SINE_LG-2:0] j;
  logic               at_peak;
  logic [MAG_W-1:0]   mag_d;
  logic [MAG_W-1:0]   mag_q;
  logic               neg_q;

  // Fold the full-turn index onto the first quadrant
  assign quad    = idx_i[SINE_LG-1 -: 2];
  assign r       = idx_i[SINE_LG-3:0];
  assign j       = quad[0] ? (QTR_J - {1'b0, r}) : {1'b0, r};
  assign at_peak = j[SINE_LG-2];
  assign mag_d   = at_peak ? SINE_PEAK : QTAB[j[SINE_LG-3:0]];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= quad[1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// File: hw/rtl/vsr_sequencer.sv
// ----------------------------------------------------------------------------
// vsr_sequencer
// Step counter and microcode ROM; one control word per step, with branches.
// ----------------------------------------------------------------------------
module vsr_sequencer
  import vsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vsr_status_t status_i,
  output vsr_ctrl_t   ctrl_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL_PH = 5'd4;

  logic [4:0] step_q;
  logic [4:0] step_d;
  vsr_uword_t uw;

  function automatic vsr_uword_t mk(input vsr_op_e op, input vsr_lane_t lane,
                                    input vsr_jump_e jump, input logic [4:0] target);
    vsr_uword_t w;
    w.op     = op;
    w.lane   = lane;
    w.jump   = jump;
    w.target = target;
    return w;
  endfunction

  // Microprogram: bookkeeping, two products, three legs of four steps, then emit
  function automatic vsr_uword_t ucode(input logic [4:0] s);
    vsr_uword_t w;
    case (s)
      5'd0:    w = mk(OP_NOP,      2'd0, JC_WAIT_IN,  S_IDLE);
      5'd1:    w = mk(OP_TIMEOUT,  2'd0, JC_NEXT,     S_IDLE);
      5'd2:    w = mk(OP_NOP,      2'd0, JC_IF_HOLD,  S_MUL_PH);
      5'd3:    w = mk(OP_RAMP,     2'd0, JC_NEXT,     S_IDLE);
      5'd4:    w = mk(OP_MUL_PH,   2'd0, JC_NEXT,     S_IDLE);
      5'd5:    w = mk(OP_ACC_PH,   2'd0, JC_NEXT,     S_IDLE);
      5'd6:    w = mk(OP_MUL_AMP,  2'd0, JC_NEXT,     S_IDLE);
      5'd7:    w = mk(OP_AMP_SAT,  2'd0, JC_NEXT,     S_IDLE);
      5'd8:    w = mk(OP_PHASE,    2'd0, JC_NEXT,     S_IDLE);
      5'd9:    w = mk(OP_LOOKUP,   2'd0, JC_NEXT,     S_IDLE);
      5'd10:   w = mk(OP_MUL_DUTY, 2'd0, JC_NEXT,     S_IDLE);
      5'd11:   w = mk(OP_DUTY,     2'd0, JC_NEXT,     S_IDLE);
      5'd12:   w = mk(OP_PHASE,    2'd1, JC_NEXT,     S_IDLE);
      5'd13:   w = mk(OP_LOOKUP,   2'd1, JC_NEXT,     S_IDLE);
      5'd14:   w = mk(OP_MUL_DUTY, 2'd1, JC_NEXT,     S_IDLE);
      5'd15:   w = mk(OP_DUTY,     2'd1, JC_NEXT,     S_IDLE);
      5'd16:   w = mk(OP_PHASE,    2'd2, JC_NEXT,     S_IDLE);
      5'd17:   w = mk(OP_LOOKUP,   2'd2, JC_NEXT,     S_IDLE);
      5'd18:   w = mk(OP_MUL_DUTY, 2'd2, JC_NEXT,     S_IDLE);
      5'd19:   w = mk(OP_DUTY,     2'd2, JC_NEXT,     S_IDLE);
      5'd20:   w = mk(OP_EMIT,     2'd0, JC_WAIT_OUT, S_IDLE);
      default: w = mk(OP_NOP,      2'd0, JC_GOTO,     S_IDLE);
    endcase
    return w;
  endfunction

  assign uw = ucode(step_q);

  // Next step
  always_comb begin
    case (uw.jump)
      JC_NEXT:     step_d = step_q + 5'd1;
      JC_GOTO:     step_d = uw.target;
      JC_WAIT_IN:  step_d = status_i.in_fire ? (step_q + 5'd1) : step_q;
      JC_IF_HOLD:  step_d = status_i.rising ? (step_q + 5'd1) : uw.target;
      JC_WAIT_OUT: step_d = status_i.out_free ? uw.target : step_q;
      default:     step_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.lane = uw.lane;
  assign ctrl_o.idle = (step_q == S_IDLE);

endmodule

// File: hw/rtl/vsr_datapath.sv
// ----------------------------------------------------------------------------
// vsr_datapath
// Ramp state, shared 24x24 multiplier, amplitude and duty arithmetic.
// ----------------------------------------------------------------------------
module vsr_datapath
  import vsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vsr_ctrl_t   ctrl_i,
  input  vsr_cfg_t    cfg_i,
  input  logic        in_fire_i,
  input  logic [31:0] now_ms_i,
  output logic        rising_o,
  output logic [23:0] speed_o,
  output vsr_duty_t   duty_o
);

  // Architectural state
  logic [23:0] speed_q, speed_d;
  logic [31:0] phase_q, phase_d;
  logic        rising_q, rising_d;
  logic [31:0] last_q, last_d;

  // Working registers
  logic [31:0]        now_q;
  logic [47:0]        mul_q;
  logic [16:0]        amp_q;
  logic [SINE_LG-1:0] idx_q;
  vsr_duty_t          duty_q;

  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic        mul_en;

  logic [31:0] gap;
  logic [24:0] ramp_next;
  logic [32:0] amp_sum;
  logic [31:0] leg_off;
  logic [31:0] leg_phase;

  logic [MAG_W-1:0] lut_mag;
  logic             lut_neg;

  logic [31:0]        dmag;
  logic signed [32:0] dprod;
  logic signed [16:0] dfloor;
  logic signed [17:0] dsum;
  logic [15:0]        duty_val;

  // Sine lookup, read on the lookup step
  vsr_sine_lut u_lut (
    .clk_i (clk_i),
    .en_i  (ctrl_i.op == OP_LOOKUP),
    .idx_i (idx_q),
    .mag_o (lut_mag),
    .neg_o (lut_neg)
  );

  // Ramp and phase bookkeeping
  assign gap       = now_q - last_q;
  assign ramp_next = {1'b0, speed_q} + {5'b0, cfg_i.ramp_step};

  always_comb begin
    speed_d  = speed_q;
    phase_d  = phase_q;
    rising_d = rising_q;
    last_d   = last_q;
    case (ctrl_i.op)
      OP_TIMEOUT: begin
        last_d = now_q;
        if (gap > {16'b0, cfg_i.timeout_ms}) begin
          speed_d  = '0;
          phase_d  = '0;
          rising_d = 1'b1;
        end
      end
      OP_RAMP: begin
        if (ramp_next >= {1'b0, cfg_i.target_speed}) begin
          speed_d  = cfg_i.target_speed;
          rising_d = 1'b0;
        end else begin
          speed_d = ramp_next[23:0];
        end
      end
      OP_ACC_PH: phase_d = phase_q + mul_q[47:16];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= '0;
      phase_q  <= '0;
      rising_q <= 1'b1;
      last_q   <= '0;
    end else begin
      speed_q  <= speed_d;
      phase_q  <= phase_d;
      rising_q <= rising_d;
      last_q   <= last_d;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a  = speed_q;
    mul_b  = cfg_i.phase_gain;
    mul_en = 1'b0;
    case (ctrl_i.op)
      OP_MUL_PH: begin
        mul_en = 1'b1;
      end
      OP_MUL_AMP: begin
        mul_b  = cfg_i.amplitude_slope;
        mul_en = 1'b1;
      end
      OP_MUL_DUTY: begin
        mul_a  = {7'b0, amp_q};
        mul_b  = {7'b0, lut_mag};
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  // Amplitude, saturated at full scale
  assign amp_sum = {17'b0, cfg_i.min_amplitude} + {1'b0, mul_q[47:16]};

  // Leg phase for the table index
  always_comb begin
    case (ctrl_i.lane)
      2'd1:    leg_off = OFFSET_B;
      2'd2:    leg_off = OFFSET_C;
      default: leg_off = '0;
    endcase
  end
  assign leg_phase = phase_q + leg_off;

  // Duty = 32768 + floor(amp * sine / 65536), clipped to 16 bits
  assign dmag     = mul_q[31:0];
  assign dprod    = lut_neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  assign dfloor   = $signed(dprod[32:16]);
  assign dsum     = 18'sd32768 + {dfloor[16], dfloor};
  assign duty_val = (dsum > 18'sd65535) ? 16'hFFFF :
                    (dsum < 18'sd0)     ? 16'h0000 : dsum[15:0];

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      now_q <= now_ms_i;
    end
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    if (ctrl_i.op == OP_AMP_SAT) begin
      amp_q <= (amp_sum > {16'b0, FULL_AMP}) ? FULL_AMP : amp_sum[16:0];
    end
    if (ctrl_i.op == OP_PHASE) begin
      idx_q <= leg_phase[31 -: SINE_LG];
    end
    if (ctrl_i.op == OP_DUTY) begin
      case (ctrl_i.lane)
        2'd0:    duty_q[0] <= duty_val;
        2'd1:    duty_q[1] <= duty_val;
        2'd2:    duty_q[2] <= duty_val;
        default: ;
      endcase
    end
  end

  assign rising_o = rising_q;
  assign speed_o  = speed_q;
  assign duty_o   = duty_q;

endmodule

// File: tb/sv/vf_startup_ramp_three_phase_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_startup_ramp_three_phase_test: self-checking bench for the V/f ramp block
// Time stamps go in as requests with random gaps and output stalls. A small
// scoreboard keeps its own copy of the ramp state, the phase accumulator and a
// sine table, predicts the three duties, speed and ramp flag for every request
// and compares them in order with what the block returns.
// ----------------------------------------------------------------------------
module vf_startup_ramp_three_phase_test;
  import vsr_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 25;
  localparam int HOLD_OFF_LEN  = 400;

  // Indexes past the register list; writes there must be dropped
  localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [23:0] speed_now;
    logic        ramping;
  } ramp_result_t;

  // Predicts one result per request and checks results in arrival order
  class vf_ramp_scoreboard;
    int           sine_lut [SINE_TABLE_DEPTH];
    logic [19:0]  step_per_tick;
    logic [23:0]  speed_target;
    logic [23:0]  phase_per_speed;
    logic [15:0]  amp_floor;
    logic [23:0]  amp_per_speed;
    logic [15:0]  restart_gap_ms;
    logic [23:0]  speed_q10;
    logic [31:0]  phase_turn;
    bit           ramp_armed;
    logic [31:0]  prev_stamp;
    ramp_result_t pending_results [$];
    int           mismatches;

    function new();
      int                quad;
      int                rem;
      longint unsigned   num;
      longint unsigned   x;
      longint unsigned   mag;
      step_per_tick   = RST_RAMP_STEP;
      speed_target    = RST_TARGET_SPEED;
      phase_per_speed = RST_PHASE_GAIN;
      amp_floor       = RST_MIN_AMPLITUDE;
      amp_per_speed   = RST_AMPLITUDE_SLOPE;
      restart_gap_ms  = RST_TIMEOUT_MS;
      speed_q10       = '0;
      phase_turn      = '0;
      ramp_armed      = 1'b1;
      prev_stamp      = '0;
      mismatches      = 0;
      // Full-wave table: fold each point into the first quadrant
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
        quad = (4 * k) / SINE_TABLE_DEPTH;
        rem  = (4 * k) % SINE_TABLE_DEPTH;
        num  = (quad % 2 == 1) ? longint'(SINE_TABLE_DEPTH - rem) : longint'(rem);
        x    = (num * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        mag  = (sin_quadrant_q30(x) + 64'd16384) >> 15;
        sine_lut[k] = (quad >= 2) ? -int'(mag) : int'(mag);
      end
    endfunction

    // Taylor series up to x^11, Q2.30, every product truncated
    function longint unsigned sin_quadrant_q30(longint unsigned x);
      longint unsigned x_sq;
      longint unsigned term;
      longint unsigned acc;
      x_sq = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      return acc;
    endfunction

    function void apply_setting(logic [2:0] idx, logic [23:0] data);
      case (idx)
        REG_RAMP_STEP:       step_per_tick   = data[19:0];
        REG_TARGET_SPEED:    speed_target    = data;
        REG_PHASE_GAIN:      phase_per_speed = data;
        REG_MIN_AMPLITUDE:   amp_floor       = data[15:0];
        REG_AMPLITUDE_SLOPE: amp_per_speed   = data;
        REG_TIMEOUT_MS:      restart_gap_ms  = data[15:0];
        default: ;
      endcase
    endfunction

    // Offset duty of one leg: 32768 + floor(amp * sine / 2^16), clamped
    function logic [15:0] leg_duty(logic [16:0] amp, logic [31:0] phase);
      longint unsigned idx;
      longint          prod;
      longint          level;
      idx   = (64'(phase) * SINE_TABLE_DEPTH) >> 32;
      prod  = longint'(amp) * longint'(sine_lut[idx]);
      level = (prod >>> 16) + 32768;
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      return level[15:0];
    endfunction

    function void note_request(logic [31:0] stamp);
      logic [31:0]  gap;
      logic [31:0]  climb;
      logic [63:0]  amp;
      ramp_result_t want;
      // Long silence restarts the ramp from standstill
      gap = stamp - prev_stamp;
      if (gap > 32'(restart_gap_ms)) begin
        speed_q10  = '0;
        phase_turn = '0;
        ramp_armed = 1'b1;
      end
      prev_stamp = stamp;
      if (ramp_armed) begin
        climb = 32'(speed_q10) + 32'(step_per_tick);
        if (climb >= 32'(speed_target)) begin
          climb      = 32'(speed_target);
          ramp_armed = 1'b0;
        end
        speed_q10 = climb[23:0];
      end
      phase_turn += 32'((64'(speed_q10) * 64'(phase_per_speed)) >> 16);
      amp = 64'(amp_floor) + ((64'(speed_q10) * 64'(amp_per_speed)) >> 16);
      if (amp > 64'(FULL_AMP)) amp = 64'(FULL_AMP);
      want.duty_a    = leg_duty(amp[16:0], phase_turn);
      want.duty_b    = leg_duty(amp[16:0], phase_turn + OFFSET_B);
      want.duty_c    = leg_duty(amp[16:0], phase_turn + OFFSET_C);
      want.speed_now = speed_q10;
      want.ramping   = ramp_armed;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(ramp_result_t got);
      ramp_result_t want;
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("duty_a", 32'(want.duty_a), 32'(got.duty_a));
      compare_field("duty_b", 32'(want.duty_b), 32'(got.duty_b));
      compare_field("duty_c", 32'(want.duty_c), 32'(got.duty_c));
      compare_field("speed_now", 32'(want.speed_now), 32'(got.speed_now));
      compare_field("ramping", 32'(want.ramping), 32'(got.ramping));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [31:0] now_ms_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] duty_a_o;
  logic [15:0] duty_b_o;
  logic [15:0] duty_c_o;
  logic [23:0] speed_now_o;
  logic        ramping_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i  = '0;

  vf_ramp_scoreboard ramp_sb;
  bit                idling_on         = 1'b1;
  int                stall_hold_cycles = 0;
  logic [31:0]       stamp_ms          = '0;

  vf_startup_ramp_three_phase dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .duty_a_o    (duty_a_o),
    .duty_b_o    (duty_b_o),
    .duty_c_o    (duty_c_o),
    .speed_now_o (speed_now_o),
    .ramping_o   (ramping_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output stall: a long hold-off when asked, random stalls otherwise while idling is on
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        stall_hold_cycles--;
      end else begin
        out_stall_i <= idling_on && ($urandom_range(99) < 35);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ramp_sb.check_result(ramp_result_t'({duty_a_o, duty_b_o, duty_c_o,
                                           speed_now_o, ramping_o}));
    end
  end

  task automatic offer_stamp(input logic [31:0] stamp);
    @(negedge clk_i);
    if (idling_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i   <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    ramp_sb.note_request(stamp);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (ramp_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ramp_sb.apply_setting(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_ramp(input logic [23:0] step, input logic [23:0] target,
                              input logic [23:0] gain, input logic [23:0] floor_amp,
                              input logic [23:0] slope, input logic [23:0] gap_ms);
    write_setting(REG_RAMP_STEP, step);
    write_setting(REG_TARGET_SPEED, target);
    write_setting(REG_PHASE_GAIN, gain);
    write_setting(REG_MIN_AMPLITUDE, floor_amp);
    write_setting(REG_AMPLITUDE_SLOPE, slope);
    write_setting(REG_TIMEOUT_MS, gap_ms);
  endtask

  // Mostly steady streams inside the timeout, some edge gaps and wild jumps
  task automatic run_stamp_stream(input int count);
    int          pick;
    int unsigned gap_ms;
    for (int i = 0; i < count; i++) begin
      pick   = $urandom_range(99);
      gap_ms = 32'(ramp_sb.restart_gap_ms);
      if (pick < 80) begin
        stamp_ms = stamp_ms + $urandom_range(gap_ms);
      end else if (pick < 86) begin
        stamp_ms = stamp_ms + gap_ms;
      end else if (pick < 92) begin
        stamp_ms = stamp_ms + gap_ms + 1;
      end else begin
        stamp_ms = $urandom();
      end
      offer_stamp(stamp_ms);
    end
    end_burst();
  endtask

  initial begin
    int unsigned cfg_target;
    int unsigned cfg_step;
    int unsigned cfg_slope;
    int unsigned cfg_gap;
    ramp_sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first request against stamp zero, gap at and past timeout,
    // all-ones stamp, then a wrap that lands exactly on the timeout
    offer_stamp(32'd0);
    offer_stamp(32'd500);
    offer_stamp(32'd1001);
    offer_stamp(32'hFFFF_FFFF);
    stamp_ms = 32'h0000_01F3;
    offer_stamp(stamp_ms);
    end_burst();
    drain_results();

    // Dropped writes, then masked writes: target reached on the first step,
    // full amplitude, phase advancing 1/64 turn per request up to the peak
    write_setting(REG_UNMAPPED_A, 24'($urandom()));
    write_setting(REG_UNMAPPED_B, 24'($urandom()));
    program_ramp(24'hF80000, 24'h080000, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
                 24'h010000);
    stamp_ms = stamp_ms + 1;
    offer_stamp(stamp_ms);
    repeat (15) offer_stamp(stamp_ms);
    end_burst();
    drain_results();

    // Zero target: restart, then the ramp stops at once
    write_setting(REG_TARGET_SPEED, 24'd0);
    stamp_ms = stamp_ms + 1;
    offer_stamp(stamp_ms);
    offer_stamp(stamp_ms);
    end_burst();
    drain_results();

    // Top of every register range, zero amplitude
    program_ramp(24'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'hFFFF);
    run_stamp_stream(200);
    drain_results();

    // Power-on settings with a long output hold-off so the input backs up
    program_ramp(24'(RST_RAMP_STEP), RST_TARGET_SPEED, RST_PHASE_GAIN,
                 24'(RST_MIN_AMPLITUDE), RST_AMPLITUDE_SLOPE, 24'(RST_TIMEOUT_MS));
    stall_hold_cycles = HOLD_OFF_LEN;
    run_stamp_stream(200);
    drain_results();

    // Random settings; the first of them runs without any idling
    for (int p = 0; p < 7; p++) begin
      idling_on  = (p != 0);
      cfg_target = ($urandom_range(3) == 0) ? $urandom_range(255)
                                            : $urandom_range(24'hFFFFFF);
      cfg_step   = cfg_target / $urandom_range(150, 3);
      if (cfg_step > 32'hFFFFF) cfg_step = 32'hFFFFF;
      if ($urandom_range(9) == 0) cfg_step = $urandom_range(24'hFFFFFF);
      if ($urandom_range(19) == 0) cfg_step = 0;
      cfg_slope  = ($urandom_range(3) == 0) ? $urandom_range(255)
                                            : $urandom_range(24'hFFFFFF);
      case ($urandom_range(3))
        0:       cfg_gap = 0;
        1:       cfg_gap = 32'hFFFF;
        default: cfg_gap = $urandom_range(3000);
      endcase
      program_ramp(24'(cfg_step), 24'(cfg_target), 24'($urandom()),
                   24'($urandom_range(16'hFFFF)), 24'(cfg_slope), 24'(cfg_gap));
      run_stamp_stream(185);
      drain_results();
    end

    if (ramp_sb.mismatches == 0 && ramp_sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
